@@ design/fpa_pkg.sv @@
// shared types and constants for the fixed-point alu
`default_nettype none
package fpa_pkg;

  typedef enum logic [3:0] {
    OP_I2F     = 4'd0,
    OP_F2I     = 4'd1,
    OP_F2I_RND = 4'd2,
    OP_ADD     = 4'd3,
    OP_SUB     = 4'd4,
    OP_MUL     = 4'd5,
    OP_DIV     = 4'd6,
    OP_ADDINT  = 4'd7,
    OP_SUBINT  = 4'd8,
    OP_MULINT  = 4'd9,
    OP_DIVINT  = 4'd10,
    OP_NONE    = 4'd15
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] a;
    logic [31:0] b;
  } item_t;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

endpackage
`default_nettype wire

@@ design/fpa_front.sv @@
// front stage: takes transactions and decodes the action into an operation class
`default_nettype none
module fpa_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [3:0]    in_action,
  input  wire logic [31:0]   in_a,
  input  wire logic [31:0]   in_b,
  output logic               out_valid,
  input  wire logic          out_ready,
  output fpa_pkg::item_t     out_item
);
  import fpa_pkg::*;

  logic  vld;
  item_t item;
  op_t   op_dec;

  always_comb begin
    unique case (in_action)
      OP_I2F:     op_dec = OP_I2F;
      OP_F2I:     op_dec = OP_F2I;
      OP_F2I_RND: op_dec = OP_F2I_RND;
      OP_ADD:     op_dec = OP_ADD;
      OP_SUB:     op_dec = OP_SUB;
      OP_MUL:     op_dec = OP_MUL;
      OP_DIV:     op_dec = OP_DIV;
      OP_ADDINT:  op_dec = OP_ADDINT;
      OP_SUBINT:  op_dec = OP_SUBINT;
      OP_MULINT:  op_dec = OP_MULINT;
      OP_DIVINT:  op_dec = OP_DIVINT;
      default:    op_dec = OP_NONE;
    endcase
  end

  assign in_ready  = !vld || out_ready;
  assign out_valid = vld;
  assign out_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item.op <= op_dec;
      item.a  <= in_a;
      item.b  <= in_b;
    end
  end

endmodule
`default_nettype wire

@@ design/fpa_queue.sv @@
// short fifo between front and back
`default_nettype none
module fpa_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire fpa_pkg::item_t in_item,
  output logic                out_valid,
  input  wire logic           out_ready,
  output fpa_pkg::item_t      out_item
);
  import fpa_pkg::*;

  item_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   count;
  logic              push;
  logic              pop;

  assign in_ready  = count != (QPTR_W+1)'(QUEUE_DEPTH);
  assign out_valid = count != '0;
  assign out_item  = mem[rptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= in_item;
    end
  end

endmodule
`default_nettype wire

@@ design/fpa_back.sv @@
// back end: operand prep, multiplier, pipelined restoring divider, result register
`default_nettype none
module fpa_back #(
  parameter int FRACTION_BITS = 14
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire fpa_pkg::item_t in_item,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [31:0]         out_result,
  output logic                out_dz,
  output logic                out_ovf
);
  import fpa_pkg::*;

  localparam int DW = 32 + FRACTION_BITS;
  localparam int NS = DW + 2;
  localparam logic signed [63:0] SCALE = 64'sd1 <<< FRACTION_BITS;
  localparam logic signed [63:0] HALF  = SCALE >>> 1;
  localparam logic signed [63:0] BIAS  = SCALE - 64'sd1;

  typedef struct packed {
    op_t                op;
    logic               dz;
    logic               qneg;
    logic signed [63:0] r;
    logic [31:0]        rem;
    logic [DW-1:0]      work;
    logic [31:0]        dsr;
  } stage_t;

  function automatic stage_t div_step(input stage_t x);
    stage_t     y;
    logic [32:0] t;
    logic [32:0] d;
    y = x;
    t = {x.rem, x.work[DW-1]};
    d = {1'b0, x.dsr};
    if (t >= d) begin
      y.rem  = 32'(t - d);
      y.work = {x.work[DW-2:0], 1'b1};
    end else begin
      y.rem  = t[31:0];
      y.work = {x.work[DW-2:0], 1'b0};
    end
    return y;
  endfunction

  logic [NS-1:0]      vld;
  stage_t             pipe [NS];
  logic               en;
  stage_t             s0_next;
  stage_t             s1_next;
  logic signed [31:0] sa;
  logic signed [31:0] sb;
  logic signed [63:0] a64;
  logic signed [63:0] b64;
  logic signed [63:0] ma;
  logic signed [63:0] rnd;
  logic signed [63:0] ash;
  logic signed [63:0] prod;
  logic [63:0]        q64;
  logic signed [63:0] r_fin;
  logic               is_div;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  assign sa   = in_item.a;
  assign sb   = in_item.b;
  assign a64  = 64'(sa);
  assign b64  = 64'(sb);
  assign ma   = sa[31] ? -a64 : a64;
  assign prod = sa * sb;
  assign ash  = ma <<< FRACTION_BITS;
  assign rnd  = (ma + HALF) >>> FRACTION_BITS;

  always_comb begin
    s0_next      = '0;
    s0_next.op   = in_item.op;
    s0_next.qneg = sa[31] ^ sb[31];
    s0_next.dsr  = sb[31] ? 32'(-b64) : 32'(b64);
    s0_next.work = (in_item.op == OP_DIV) ? ash[DW-1:0] : ma[DW-1:0];
    case (in_item.op)
      OP_I2F:     s0_next.r = a64 <<< FRACTION_BITS;
      OP_F2I:     s0_next.r = (a64 + (sa[31] ? BIAS : 64'sd0)) >>> FRACTION_BITS;
      OP_F2I_RND: s0_next.r = sa[31] ? -rnd : rnd;
      OP_ADD:     s0_next.r = a64 + b64;
      OP_SUB:     s0_next.r = a64 - b64;
      OP_ADDINT:  s0_next.r = a64 + (b64 <<< FRACTION_BITS);
      OP_SUBINT:  s0_next.r = a64 - (b64 <<< FRACTION_BITS);
      OP_MUL,
      OP_MULINT:  s0_next.r = prod;
      OP_DIV,
      OP_DIVINT:  s0_next.dz = (sb == 32'sd0);
      default:    s0_next.r = 64'sd0;
    endcase
  end

  // truncating scale-down of the product happens one stage after the multiply
  always_comb begin
    s1_next = pipe[0];
    if (pipe[0].op == OP_MUL) begin
      s1_next.r = (pipe[0].r + (pipe[0].r[63] ? BIAS : 64'sd0)) >>> FRACTION_BITS;
    end
  end

  assign is_div = (pipe[NS-1].op == OP_DIV) || (pipe[NS-1].op == OP_DIVINT);
  assign q64    = 64'(pipe[NS-1].work);

  always_comb begin
    r_fin = pipe[NS-1].r;
    if (is_div) begin
      if (pipe[NS-1].dz) begin
        r_fin = 64'sd0;
      end else if (pipe[NS-1].qneg) begin
        r_fin = -$signed(q64);
      end else begin
        r_fin = $signed(q64);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[NS-2:0], in_valid};
      out_valid <= vld[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pipe[0] <= s0_next;
      pipe[1] <= s1_next;
      for (int k = 2; k < NS; k++) begin
        pipe[k] <= div_step(pipe[k-1]);
      end
      out_result <= r_fin[31:0];
      out_dz     <= is_div && pipe[NS-1].dz;
      out_ovf    <= !((&r_fin[63:31]) || !(|r_fin[63:31]));
    end
  end

endmodule
`default_nettype wire

@@ design/fixed_point_alu.sv @@
// top level of the signed fixed-point alu
// Signed fixed-point ALU with FRACTION_BITS fraction bits (Q17.14 by default). Each input
// transaction carries an action code in s_tuser and two 32-bit two's-complement operands in
// s_tdata; exactly one result transaction comes back per input, in order. Supported actions:
// int to fixed, fixed to int truncating, fixed to int rounding half away from zero, fixed
// add/sub/mul/div and mixed fixed-with-integer add/sub/mul/div. Results are the low 32 bits
// of the exact value, with an overflow flag when it does not fit 32 signed bits; a zero
// divisor gives result 0 with divide_by_zero set, and unknown actions give 0. One transaction
// is accepted per clock cycle when the output side keeps up. On its way to m_tvalid each
// transaction passes the front register, the fifo, then the back pipe, whose length is set
// by the divider, which resolves one quotient bit per pipeline stage over 32 + FRACTION_BITS
// stages, and the result register; every operation runs down the same pipe to keep order. A
// small fifo between the decode front and the execution back absorbs short output stalls.
`default_nettype none
module fixed_point_alu #(
  parameter int FRACTION_BITS = 14
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // operand_a[31:0], operand_b[63:32]
  input  wire logic [3:0]  s_tuser,   // action[3:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // result[31:0]
  output logic [1:0]       m_tuser    // divide_by_zero[0], overflow[1]
);
  import fpa_pkg::*;

  // front to queue
  logic  f_valid;
  logic  f_ready;
  item_t f_item;
  // queue to back
  logic  q_valid;
  logic  q_ready;
  item_t q_item;

  fpa_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_action (s_tuser),
    .in_a      (s_tdata[31:0]),
    .in_b      (s_tdata[63:32]),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_item  (f_item)
  );

  fpa_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_item   (f_item),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_item  (q_item)
  );

  // back end stalls its whole pipe only when the result register is held
  fpa_back #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (q_valid),
    .in_ready   (q_ready),
    .in_item    (q_item),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_result (m_tdata),
    .out_dz     (m_tuser[0]),
    .out_ovf    (m_tuser[1])
  );

endmodule
`default_nettype wire
